// File: sv/flh_pkg.sv
// Shared package for the frame luma hysteresis switch.
// Holds the sizing constants, register indexes, state codes and the controller/datapath structs.
`timescale 1ns / 1ps
`default_nettype none

package flh_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1048576;
  localparam int unsigned FIRST_SAMPLE    = 200;
  localparam int unsigned SAMPLE_STRIDE   = 64;
  localparam int unsigned STRIDE_W        = $clog2(SAMPLE_STRIDE);
  localparam int unsigned IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CNT_W           =
      $clog2((MAX_FRAME_BYTES - FIRST_SAMPLE) / SAMPLE_STRIDE + 2);
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned THR_W           = 8;
  localparam int unsigned SUM_W           = CNT_W + BYTE_W;
  localparam int unsigned FRAC_W          = 4;
  localparam int unsigned LUMA_W          = 12;
  localparam int unsigned DVD_W           = SUM_W + FRAC_W;
  localparam int unsigned PROD_W          = CNT_W + THR_W;
  localparam int unsigned STEP_W          = $clog2(LUMA_W);
  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned REG_IDX_W       = 2;

  localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(LUMA_W - 1);
  localparam logic [SUM_W-1:0]  NO_SAMPLE_MEAN = SUM_W'(128);
  localparam logic [LUMA_W-1:0] LUMA_DEFAULT   = LUMA_W'(2048);
  localparam logic [THR_W-1:0]  IR_ON_RESET    = THR_W'(72);
  localparam logic [THR_W-1:0]  IR_OFF_RESET   = THR_W'(94);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCENE_AUTO   = 2'd0,
    REG_MANUAL_IR    = 2'd1,
    REG_IR_ON_BELOW  = 2'd2,
    REG_IR_OFF_ABOVE = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic             scene_auto;
    logic             manual_ir;
    logic [THR_W-1:0] ir_on_below;
    logic [THR_W-1:0] ir_off_above;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/flh_ctrl.sv
// Controller state machine for the frame luma hysteresis switch.
// Sequences byte intake, divider set-up, the divider steps and the frame-end update; uses flh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flh_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  frame_end_i,
  input  flh_pkg::dp_status_t  status_i,
  output flh_pkg::dp_cmd_t     cmd_o,
  output logic                 in_stall_o
);

  flh_pkg::state_e              state_q, state_d;
  logic [flh_pkg::STEP_W-1:0]   step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flh_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      flh_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && frame_end_i) begin
          state_d = flh_pkg::ST_PREP;
        end
      end
      flh_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = flh_pkg::ST_DIV;
      end
      flh_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + flh_pkg::STEP_W'(1);
        if (step_q == flh_pkg::STEP_LAST) begin
          state_d = flh_pkg::ST_FIN;
        end
      end
      flh_pkg::ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = flh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = flh_pkg::ST_IDLE;
      end
    endcase
  end

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flh_pkg::ST_DIV && step_q == flh_pkg::STEP_LAST)
      |=> (state_q == flh_pkg::ST_FIN))
    else $error("divider did not hand over to the frame-end update");

  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flh_pkg::ST_IDLE && in_valid_i && frame_end_i)
      |=> (state_q == flh_pkg::ST_PREP))
    else $error("last byte of a frame did not start the frame-end work");

endmodule

`default_nettype wire

// File: sv/flh_dp.sv
// Datapath for the frame luma hysteresis switch: sampling, sum and count, the
// shift-subtract divider, threshold compare and the result register; uses flh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flh_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  flh_pkg::dp_cmd_t             cmd_i,
  output flh_pkg::dp_status_t          status_o,
  input  flh_pkg::cfg_t                cfg_i,
  input  wire [flh_pkg::BYTE_W-1:0]    byte_value_i,
  input  wire                          out_stall_i,
  output logic                         out_valid_o,
  output logic [flh_pkg::LUMA_W-1:0]   scene_luma_q4_o,
  output logic                         ir_on_o,
  output logic                         ir_changed_o,
  output logic                         no_samples_o
);

  logic [flh_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [flh_pkg::BYTE_W-1:0]   pend_q, pend_d;
  logic                         have_pend_q, have_pend_d;
  logic [flh_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [flh_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                         mode_q, mode_d;
  logic [flh_pkg::LUMA_W-1:0]   luma_q, luma_d;
  logic                         out_valid_q, out_valid_d;

  logic [flh_pkg::CNT_W-1:0]    rem_q;
  logic [flh_pkg::LUMA_W-1:0]   dlo_q;
  logic [flh_pkg::LUMA_W-1:0]   quot_q;
  logic [flh_pkg::PROD_W-1:0]   prod_on_q, prod_off_q;
  logic [flh_pkg::LUMA_W-1:0]   out_luma_q;
  logic                         out_ir_q, out_chg_q, out_none_q;

  logic                         in_range, hit, none;
  logic [flh_pkg::SUM_W-1:0]    s_eff;
  logic [flh_pkg::CNT_W-1:0]    c_eff;
  logic [flh_pkg::DVD_W-1:0]    dividend;
  logic [flh_pkg::CNT_W:0]      rem_sh, trial;
  logic                         fits;
  logic [flh_pkg::CNT_W-1:0]    rem_next;

  assign in_range = (idx_q < flh_pkg::IDX_W'(flh_pkg::MAX_FRAME_BYTES));
  assign hit = in_range && (idx_q >= flh_pkg::IDX_W'(flh_pkg::FIRST_SAMPLE)) &&
               (idx_q[flh_pkg::STRIDE_W-1:0] ==
                flh_pkg::STRIDE_W'(flh_pkg::FIRST_SAMPLE % flh_pkg::SAMPLE_STRIDE));
  assign none     = (cnt_q == '0);
  assign s_eff    = none ? flh_pkg::NO_SAMPLE_MEAN : sum_q;
  assign c_eff    = none ? flh_pkg::CNT_W'(1) : cnt_q;
  assign dividend = {sum_q, {flh_pkg::FRAC_W{1'b0}}};
  assign rem_sh   = {rem_q, dlo_q[flh_pkg::LUMA_W-1]};
  assign trial    = rem_sh - {1'b0, c_eff};
  assign fits     = (rem_sh >= {1'b0, c_eff});
  assign rem_next = fits ? trial[flh_pkg::CNT_W-1:0] : rem_sh[flh_pkg::CNT_W-1:0];

  always_comb begin
    idx_d       = idx_q;
    pend_d      = pend_q;
    have_pend_d = have_pend_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    luma_d      = luma_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.accept) begin
      if (hit) begin
        if (have_pend_q) begin
          sum_d = sum_q + flh_pkg::SUM_W'(pend_q);
          cnt_d = cnt_q + flh_pkg::CNT_W'(1);
        end
        pend_d      = byte_value_i;
        have_pend_d = 1'b1;
      end
      if (in_range) begin
        idx_d = idx_q + flh_pkg::IDX_W'(1);
      end
    end
    if (cmd_i.finish) begin
      if (cfg_i.scene_auto) begin
        luma_d = none ? flh_pkg::LUMA_DEFAULT : quot_q;
        if (s_eff < prod_on_q) begin
          mode_d = 1'b1;
        end else if (s_eff > prod_off_q) begin
          mode_d = 1'b0;
        end
      end else begin
        mode_d = cfg_i.manual_ir;
      end
      idx_d       = '0;
      pend_d      = '0;
      have_pend_d = 1'b0;
      sum_d       = '0;
      cnt_d       = '0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pend_q      <= '0;
      have_pend_q <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      luma_q      <= flh_pkg::LUMA_DEFAULT;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      have_pend_q <= have_pend_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      luma_q      <= luma_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      rem_q      <= dividend[flh_pkg::DVD_W-1:flh_pkg::LUMA_W];
      dlo_q      <= dividend[flh_pkg::LUMA_W-1:0];
      quot_q     <= '0;
      prod_on_q  <= flh_pkg::PROD_W'(cfg_i.ir_on_below) * flh_pkg::PROD_W'(c_eff);
      prod_off_q <= flh_pkg::PROD_W'(cfg_i.ir_off_above) * flh_pkg::PROD_W'(c_eff);
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_next;
      dlo_q  <= {dlo_q[flh_pkg::LUMA_W-2:0], 1'b0};
      quot_q <= {quot_q[flh_pkg::LUMA_W-2:0], fits};
    end
    if (cmd_i.finish) begin
      out_luma_q <= luma_d;
      out_ir_q   <= mode_d;
      out_chg_q  <= (mode_d != mode_q);
      out_none_q <= none;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign scene_luma_q4_o   = out_luma_q;
  assign ir_on_o           = out_ir_q;
  assign ir_changed_o      = out_chg_q;
  assign no_samples_o      = out_none_q;

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (idx_q == '0 && cnt_q == '0 && !have_pend_q))
    else $error("frame state not cleared after the frame end");

  a_sum_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0))
    else $error("sample sum is nonzero with no counted sample");

endmodule

`default_nettype wire

// File: sv/frame_luma_hysteresis_switch_unit.sv
// Top level of the frame luma hysteresis switch: register port, controller and datapath.
// A byte that is not the last of its frame is taken without a stall; the next may follow at once.
// The last byte starts a 12-step shift-subtract divide; input stays stalled until the result
// enters the output register, which waits while an earlier result is held by the output stall.
// Reset (rst_ni low, asynchronous) clears the frame, sets infrared off and luma to 128.0,
// and loads the register reset values. Depends on flh_pkg, flh_ctrl and flh_dp.
`timescale 1ns / 1ps
`default_nettype none

module frame_luma_hysteresis_switch_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [flh_pkg::ADDR_W-1:0]    paddr,
  input  wire [flh_pkg::DATA_W-1:0]    pwdata,
  output logic [flh_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [flh_pkg::BYTE_W-1:0]    byte_value_i,
  input  wire                          frame_end_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [flh_pkg::LUMA_W-1:0]   scene_luma_q4_o,
  output logic                         ir_on_o,
  output logic                         ir_changed_o,
  output logic                         no_samples_o
);

  flh_pkg::cfg_t        cfg_q, cfg_d;
  flh_pkg::reg_idx_e    reg_idx;
  logic                 wr_en;
  flh_pkg::dp_cmd_t     cmd;
  flh_pkg::dp_status_t  status;

  assign pready  = 1'b1;
  assign reg_idx = flh_pkg::reg_idx_e'(paddr[flh_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        flh_pkg::REG_SCENE_AUTO:   cfg_d.scene_auto   = pwdata[0];
        flh_pkg::REG_MANUAL_IR:    cfg_d.manual_ir    = pwdata[0];
        flh_pkg::REG_IR_ON_BELOW:  cfg_d.ir_on_below  = pwdata[flh_pkg::THR_W-1:0];
        flh_pkg::REG_IR_OFF_ABOVE: cfg_d.ir_off_above = pwdata[flh_pkg::THR_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      flh_pkg::REG_SCENE_AUTO:   prdata = flh_pkg::DATA_W'(cfg_q.scene_auto);
      flh_pkg::REG_MANUAL_IR:    prdata = flh_pkg::DATA_W'(cfg_q.manual_ir);
      flh_pkg::REG_IR_ON_BELOW:  prdata = flh_pkg::DATA_W'(cfg_q.ir_on_below);
      flh_pkg::REG_IR_OFF_ABOVE: prdata = flh_pkg::DATA_W'(cfg_q.ir_off_above);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scene_auto   <= 1'b1;
      cfg_q.manual_ir    <= 1'b0;
      cfg_q.ir_on_below  <= flh_pkg::IR_ON_RESET;
      cfg_q.ir_off_above <= flh_pkg::IR_OFF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  flh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  flh_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_i           (cfg_q),
    .byte_value_i    (byte_value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .scene_luma_q4_o (scene_luma_q4_o),
    .ir_on_o         (ir_on_o),
    .ir_changed_o    (ir_changed_o),
    .no_samples_o    (no_samples_o)
  );

endmodule

`default_nettype wire

// File: verif/luma_switch_checker.sv
// Checker for the frame luma hysteresis switch: tracks register writes and accepted bytes,
// predicts each frame's result and compares it with what the block delivers.
// Depends on flh_pkg for sizes, register indexes and the configuration struct.
`timescale 1ns / 1ps

module luma_switch_checker
  import flh_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [ADDR_W-1:0]  paddr,
  input  wire [DATA_W-1:0]  pwdata,
  input  wire               pready,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire [BYTE_W-1:0]  byte_value_i,
  input  wire               frame_end_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire [LUMA_W-1:0]  scene_luma_q4_i,
  input  wire               ir_on_i,
  input  wire               ir_changed_i,
  input  wire               no_samples_i,
  output int                mismatch_count_o,
  output int                frames_pending_o
);

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              ir_on;
    logic              ir_changed;
    logic              no_samples;
  } frame_result_t;

  frame_result_t     frame_result_q[$];
  cfg_t              cfg;
  int unsigned       frame_pos;
  logic [BYTE_W-1:0] held_byte;
  logic              held_valid;
  longint unsigned   acc_sum;
  longint unsigned   acc_count;
  logic              ir_state;
  logic [LUMA_W-1:0] luma_kept;

  function automatic void clear_frame();
    frame_pos  = 0;
    held_byte  = '0;
    held_valid = 1'b0;
    acc_sum    = 0;
    acc_count  = 0;
  endfunction

  function automatic void write_register(input logic [ADDR_W-1:0] addr,
                                         input logic [DATA_W-1:0] data);
    case (reg_idx_e'(addr[2 +: REG_IDX_W]))
      REG_SCENE_AUTO:   cfg.scene_auto   = data[0];
      REG_MANUAL_IR:    cfg.manual_ir    = data[0];
      REG_IR_ON_BELOW:  cfg.ir_on_below  = data[THR_W-1:0];
      REG_IR_OFF_ABOVE: cfg.ir_off_above = data[THR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
    longint unsigned mean_sum;
    longint unsigned mean_div;
    logic            was_on;
    logic            none;
    frame_result_t   r;
    if (frame_pos < MAX_FRAME_BYTES && frame_pos >= FIRST_SAMPLE &&
        (frame_pos - FIRST_SAMPLE) % SAMPLE_STRIDE == 0) begin
      if (held_valid) begin
        acc_sum   = acc_sum + held_byte;
        acc_count = acc_count + 1;
      end
      held_byte  = b;
      held_valid = 1'b1;
    end
    if (frame_pos < MAX_FRAME_BYTES) frame_pos = frame_pos + 1;
    if (last) begin
      was_on   = ir_state;
      none     = (acc_count == 0);
      mean_sum = none ? 128 : acc_sum;
      mean_div = none ? 1 : acc_count;
      if (cfg.scene_auto) begin
        luma_kept = none ? LUMA_DEFAULT : LUMA_W'((mean_sum << FRAC_W) / mean_div);
        if (mean_sum < longint'(cfg.ir_on_below) * mean_div) begin
          ir_state = 1'b1;
        end else if (mean_sum > longint'(cfg.ir_off_above) * mean_div) begin
          ir_state = 1'b0;
        end
      end else begin
        ir_state = cfg.manual_ir;
      end
      r.luma       = luma_kept;
      r.ir_on      = ir_state;
      r.ir_changed = (ir_state != was_on);
      r.no_samples = none;
      frame_result_q.push_back(r);
      clear_frame();
    end
  endfunction

  function automatic void check_result();
    frame_result_t got;
    frame_result_t want;
    got = {scene_luma_q4_i, ir_on_i, ir_changed_i, no_samples_i};
    if (frame_result_q.size() == 0) begin
      mismatch_count_o = mismatch_count_o + 1;
      if (mismatch_count_o <= 10)
        $display("%0t: result luma=%0d ir_on=%0b ir_changed=%0b no_samples=%0b with no frame pending",
                 $realtime, got.luma, got.ir_on, got.ir_changed, got.no_samples);
    end else begin
      want = frame_result_q.pop_front();
      if (got !== want) begin
        mismatch_count_o = mismatch_count_o + 1;
        if (mismatch_count_o <= 10)
          $display("%0t: expected luma=%0d ir_on=%0b ir_changed=%0b no_samples=%0b, got luma=%0d ir_on=%0b ir_changed=%0b no_samples=%0b",
                   $realtime, want.luma, want.ir_on, want.ir_changed, want.no_samples,
                   got.luma, got.ir_on, got.ir_changed, got.no_samples);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.scene_auto   = 1'b1;
      cfg.manual_ir    = 1'b0;
      cfg.ir_on_below  = IR_ON_RESET;
      cfg.ir_off_above = IR_OFF_RESET;
      ir_state         = 1'b0;
      luma_kept        = LUMA_DEFAULT;
      clear_frame();
      frame_result_q.delete();
      mismatch_count_o = 0;
      frames_pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) absorb_byte(byte_value_i, frame_end_i);
      frames_pending_o = frame_result_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the frame luma hysteresis switch testbench: clock, reset, frame stimulus,
// register writes, output back-pressure and the verdict. Depends on flh_pkg,
// luma_switch_checker and the frame_luma_hysteresis_switch_unit block.
`timescale 1ns / 1ps

module testbench;
  import flh_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 500;
  localparam int RANDOM_FRAMES = 30;

  typedef enum int {
    FILL_RANDOM,
    FILL_FLAT,
    FILL_NEAR
  } fill_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] byte_value = '0;
  logic              frame_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LUMA_W-1:0] scene_luma_q4;
  logic              ir_on;
  logic              ir_changed;
  logic              no_samples;

  int                mismatch_count;
  int                frames_pending;
  int                cycle_count = 0;
  bit                hold_req = 1'b0;
  bit                hold_served = 1'b0;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;
  int                cur_on = IR_ON_RESET;
  int                cur_off = IR_OFF_RESET;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  frame_luma_hysteresis_switch_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .byte_value_i    (byte_value),
    .frame_end_i     (frame_end),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .scene_luma_q4_o (scene_luma_q4),
    .ir_on_o         (ir_on),
    .ir_changed_o    (ir_changed),
    .no_samples_o    (no_samples)
  );

  luma_switch_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .byte_value_i     (byte_value),
    .frame_end_i      (frame_end),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .scene_luma_q4_i  (scene_luma_q4),
    .ir_on_i          (ir_on),
    .ir_changed_i     (ir_changed),
    .no_samples_i     (no_samples),
    .mismatch_count_o (mismatch_count),
    .frames_pending_o (frames_pending)
  );

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic int clamp_byte(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // All driving tasks are entered and left at a falling edge.
  task automatic write_reg(input reg_idx_e idx, input int value);
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_IR_ON_BELOW || idx == REG_IR_OFF_ABOVE) ? DATA_W'(8'hFF) : DATA_W'(1);
    if (idx == REG_IR_ON_BELOW) cur_on = value & 'hFF;
    if (idx == REG_IR_OFF_ABOVE) cur_off = value & 'hFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= (DATA_W'($urandom()) & ~mask) | (DATA_W'(value) & mask);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input bit fast);
    int gap;
    gap = fast ? 0 : draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    frame_end  <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int len, input fill_e fill, input int level, input bit fast);
    logic [BYTE_W-1:0] b;
    for (int k = 0; k < len; k++) begin
      case (fill)
        FILL_FLAT: b = BYTE_W'(clamp_byte(level));
        FILL_NEAR: b = BYTE_W'(clamp_byte(level + $urandom_range(0, 4) - 2));
        default:   b = BYTE_W'($urandom_range(0, 255));
      endcase
      send_byte(b, k == len - 1, fast);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (frames_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(120, 136);
    endcase
  endfunction

  task automatic shuffle_config();
    int       n;
    reg_idx_e idx;
    wait_idle();
    n = $urandom_range(1, 4);
    repeat (n) begin
      idx = reg_idx_e'($urandom_range(0, 3));
      case (idx)
        REG_SCENE_AUTO: write_reg(idx, ($urandom_range(0, 3) != 0) ? 1 : 0);
        REG_MANUAL_IR:  write_reg(idx, $urandom_range(0, 1));
        default:        write_reg(idx, pick_threshold());
      endcase
    end
  endtask

  function automatic int pick_length();
    return $urandom_range(1, 12);
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 5))
      0:       return cur_on - 1;
      1:       return cur_on;
      2:       return cur_off;
      3:       return cur_off + 1;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_served) begin
        gap         = HOLD_CYCLES;
        hold_served = 1'b1;
      end else begin
        gap = draw_wait(out_calm);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  initial begin
    fill_e fill;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // Reset settings: a single byte, then a frame with three counted samples and a dropped one.
    send_frame(1, FILL_RANDOM, 0, 0);
    send_frame(393, FILL_RANDOM, 0, 0);

    // Overlapping thresholds: the turn-on test has priority.
    wait_idle();
    write_reg(REG_IR_ON_BELOW, 255);
    write_reg(REG_IR_OFF_ABOVE, 0);
    send_frame(2, FILL_RANDOM, 0, 0);
    wait_idle();
    write_reg(REG_IR_ON_BELOW, 0);
    write_reg(REG_IR_OFF_ABOVE, 255);
    send_frame(2, FILL_RANDOM, 0, 0);

    // A frame without samples has a mean of exactly 128; on a threshold the mode holds.
    wait_idle();
    write_reg(REG_IR_ON_BELOW, 128);
    write_reg(REG_IR_OFF_ABOVE, 128);
    send_frame(3, FILL_RANDOM, 0, 0);
    wait_idle();
    write_reg(REG_IR_OFF_ABOVE, 127);
    send_frame(2, FILL_RANDOM, 0, 0);
    wait_idle();
    write_reg(REG_IR_ON_BELOW, 129);
    send_frame(2, FILL_RANDOM, 0, 0);

    // Manual control keeps the stored luma.
    wait_idle();
    write_reg(REG_SCENE_AUTO, 0);
    write_reg(REG_MANUAL_IR, 0);
    send_frame(3, FILL_RANDOM, 0, 0);
    wait_idle();
    write_reg(REG_MANUAL_IR, 1);
    send_frame(4, FILL_RANDOM, 0, 0);
    wait_idle();
    write_reg(REG_SCENE_AUTO, 1);
    write_reg(REG_IR_ON_BELOW, 72);
    write_reg(REG_IR_OFF_ABOVE, 94);
    send_frame(2, FILL_RANDOM, 0, 0);
    wait_idle();

    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      if ($urandom_range(0, 4) == 0) shuffle_config();
      if (f == RANDOM_FRAMES / 2) begin
        hold_req = 1'b1;
        repeat (12) send_frame($urandom_range(1, 6), FILL_RANDOM, 0, 0);
      end
      fill = fill_e'($urandom_range(0, 2));
      send_frame(pick_length(), fill, pick_level(), 0);
    end
    wait_idle();

    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
